### hdl/goal_reach_probability_ply_engine_top_defines.svh
// assertion macros for the goal reach probability ply engine
`ifndef GOAL_REACH_PROBABILITY_PLY_ENGINE_TOP_DEFINES_SVH
`define GOAL_REACH_PROBABILITY_PLY_ENGINE_TOP_DEFINES_SVH

// same-cycle implication
`define GRPPE_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define GRPPE_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### hdl/grppe_pkg.sv
// package with constants and payload types of the goal reach probability ply engine
package grppe_pkg;

   localparam int PLY_SIZE  = 4096;
   localparam int PLY_AW    = $clog2(PLY_SIZE);
   localparam int CARD_W    = PLY_AW + 1;
   localparam int MAX_ITEMS = 8;
   localparam int ITEM_W    = $clog2(MAX_ITEMS);
   localparam int MAX_DISTS = 16;
   localparam int DIST_W    = $clog2(MAX_DISTS);
   localparam int PROB_BITS = 32;
   localparam int FRAC      = PROB_BITS - 1;
   localparam int OC_AW     = DIST_W + ITEM_W;

   localparam logic [PROB_BITS-1:0] PROB_ONE = {1'b1, {FRAC{1'b0}}};

   localparam logic [1:0] FUNC_LOAD    = 2'd0;
   localparam logic [1:0] FUNC_RESTART = 2'd1;
   localparam logic [1:0] FUNC_STEP    = 2'd2;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_TOO_LARGE   = 2'd1;
   localparam logic [1:0] STATUS_NOT_STARTED = 2'd2;

   localparam logic [1:0] CSR_ITEM_COUNT  = 2'd0;
   localparam logic [1:0] CSR_DIST_COUNT  = 2'd1;
   localparam logic [1:0] CSR_GOAL_COUNTS = 2'd2;

   typedef struct packed {
      logic [1:0]           func;
      logic [3:0]           dist_index;
      logic [2:0]           item_index;
      logic                 outcome_present;
      logic [7:0]           reward;
      logic [PROB_BITS-1:0] probability;
   } req_type;

   typedef struct packed {
      logic [PROB_BITS-1:0] reach_prob;
      logic [1:0]           status;
      logic [15:0]          plies_done;
   } rsp_type;

endpackage

### hdl/goal_reach_probability_ply_engine_top.sv
// load, no-op and refused step pass shape check, dispatch and query only; a restart also
// clears and seeds the first ply; a step clears the destination ply, then reads each state
//   and each of the MAX_ITEMS outcome slots of a valid state
// one transaction at a time; a finished result may wait in the output register
// reset: synchronous, outcome table absent, not started, registers at defaults
`include "goal_reach_probability_ply_engine_top_defines.svh"

module goal_reach_probability_ply_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  grppe_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output grppe_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [63:0]        csr_wdata
);
   import grppe_pkg::*;

   localparam logic [3:0] ST_IDLE       = 4'd0;
   localparam logic [3:0] ST_SHAPE      = 4'd1;
   localparam logic [3:0] ST_DISPATCH   = 4'd2;
   localparam logic [3:0] ST_CLEAR      = 4'd3;
   localparam logic [3:0] ST_SRC        = 4'd4;
   localparam logic [3:0] ST_SRC_WAIT   = 4'd5;
   localparam logic [3:0] ST_OC         = 4'd6;
   localparam logic [3:0] ST_OC_WAIT    = 4'd7;
   localparam logic [3:0] ST_DST_WAIT   = 4'd8;
   localparam logic [3:0] ST_QUERY      = 4'd9;
   localparam logic [3:0] ST_QUERY_WAIT = 4'd10;

   localparam logic [CARD_W-1:0] PLY_LIMIT = CARD_W'(PLY_SIZE);

   // configuration
   logic [3:0]  item_count_ff;
   logic [4:0]  dist_count_ff;
   logic [63:0] goal_counts_ff;

   // control and payload registers
   logic [3:0]           state_ff, state_in;
   req_type              req_ff, req_in;
   logic [ITEM_W-1:0]    i_ff, i_in;
   logic [CARD_W-1:0]    c_ff, c_in;
   logic                 ok_ff, ok_in;
   logic [CARD_W-1:0]    mult_ff [MAX_ITEMS];
   logic [CARD_W-1:0]    mult_in [MAX_ITEMS];
   logic [7:0]           cnt_ff [MAX_ITEMS];
   logic [7:0]           cnt_in [MAX_ITEMS];
   logic [CARD_W-1:0]    idx_ff, idx_in;
   logic [PLY_AW-1:0]    clr_ff, clr_in;
   logic                 dst_sel_ff, dst_sel_in;
   logic [DIST_W-1:0]    d_ff, d_in;
   logic [DIST_W-1:0]    dist_ptr_ff, dist_ptr_in;
   logic                 ply_select_ff, ply_select_in;
   logic [15:0]          ply_count_ff, ply_count_in;
   logic                 started_ff, started_in;
   logic [PROB_BITS-1:0] p_ff, p_in;
   logic                 pres_ff, pres_in;
   logic [2*PROB_BITS-1:0] prod_ff, prod_in;
   logic [PLY_AW-1:0]    nidx_ff, nidx_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   logic [MAX_DISTS*MAX_ITEMS-1:0] present_ff;

   // ply memory: {valid, probability}, address {ply, state index}
   logic [PROB_BITS:0]   ply_mem [2*PLY_SIZE];
   logic [PROB_BITS:0]   ply_rdata_ff;
   logic                 mem_we, mem_re;
   logic [PLY_AW:0]      mem_waddr, mem_raddr;
   logic [PROB_BITS:0]   mem_wdata;

   // outcome memory: {reward, probability}
   logic [8+PROB_BITS-1:0] oc_mem [MAX_DISTS*MAX_ITEMS];
   logic [8+PROB_BITS-1:0] oc_rdata_ff;
   logic                   oc_we, oc_re;
   logic [OC_AW-1:0]       oc_raddr;

   logic [3:0]           items_used;
   logic [7:0]           goal_cur;
   logic [21:0]          shape_n;
   logic [4:0]           n_dist;
   logic [DIST_W-1:0]    d_sel;
   logic [4:0]           d_next;
   logic [PROB_BITS-1:0] load_prob;
   logic [8:0]           cnt_sum;
   logic [7:0]           nc;
   logic [20:0]          delta;
   logic [CARD_W+8:0]    nidx_full;
   logic [PROB_BITS:0]   q_wide;
   logic [PROB_BITS-1:0] q;
   logic [PROB_BITS:0]   sum_wide;
   logic [PROB_BITS-1:0] put_val;
   logic                 carry;
   logic [7:0]           goal_j;
   logic [PLY_AW-1:0]    query_addr;
   logic [CARD_W-1:0]    card_m1;

   function automatic logic [7:0] goal_of(input logic [ITEM_W-1:0] i,
                                          input logic [3:0] used,
                                          input logic [63:0] goals);
      logic [7:0] g;
      g = goals[8*i +: 8];
      if ({1'b0, i} < used) begin
         goal_of = g;
      end else begin
         goal_of = 8'd0;
      end
   endfunction

   assign items_used = (item_count_ff > 4'(MAX_ITEMS)) ? 4'(MAX_ITEMS) : item_count_ff;
   assign goal_cur   = goal_of(i_ff, items_used, goal_counts_ff);
   assign shape_n    = 22'(c_ff) * 22'({1'b0, goal_cur} + 9'd1);
   assign n_dist     = (dist_count_ff == 5'd0) ? 5'd1 :
                       ((dist_count_ff > 5'(MAX_DISTS)) ? 5'(MAX_DISTS) : dist_count_ff);
   assign d_sel      = ({1'b0, dist_ptr_ff} >= n_dist) ? '0 : dist_ptr_ff;
   assign d_next     = {1'b0, d_sel} + 5'd1;
   assign load_prob  = (req_ff.probability > PROB_ONE) ? PROB_ONE : req_ff.probability;
   assign card_m1    = c_ff - CARD_W'(1);
   assign query_addr = card_m1[PLY_AW-1:0];

   // count update for one outcome, clamped at the goal
   assign cnt_sum   = {1'b0, cnt_ff[i_ff]} + {1'b0, oc_rdata_ff[8+PROB_BITS-1:PROB_BITS]};
   assign nc        = (cnt_sum > {1'b0, goal_cur}) ? goal_cur : cnt_sum[7:0];
   assign delta     = ((goal_cur != 8'd0) && (cnt_ff[i_ff] < goal_cur)) ?
                      21'(nc - cnt_ff[i_ff]) * 21'(mult_ff[i_ff]) : 21'd0;
   assign nidx_full = (CARD_W+9)'(idx_ff) + (CARD_W+9)'(delta);

   // truncated product and saturated merge
   assign q_wide   = prod_ff[2*PROB_BITS-1:FRAC];
   assign q        = (q_wide > {1'b0, PROB_ONE}) ? PROB_ONE : q_wide[PROB_BITS-1:0];
   assign sum_wide = {1'b0, ply_rdata_ff[PROB_BITS-1:0]} + {1'b0, q};
   assign put_val  = !ply_rdata_ff[PROB_BITS] ? q :
                     ((sum_wide > {1'b0, PROB_ONE}) ? PROB_ONE : sum_wide[PROB_BITS-1:0]);

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      i_in          = i_ff;
      c_in          = c_ff;
      ok_in         = ok_ff;
      mult_in       = mult_ff;
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      dst_sel_in    = dst_sel_ff;
      d_in          = d_ff;
      dist_ptr_in   = dist_ptr_ff;
      ply_select_in = ply_select_ff;
      ply_count_in  = ply_count_ff;
      started_in    = started_ff;
      p_in          = p_ff;
      pres_in       = pres_ff;
      prod_in       = prod_ff;
      nidx_in       = nidx_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      oc_we         = 1'b0;
      oc_re         = 1'b0;
      oc_raddr      = {d_ff, i_ff};
      carry         = 1'b0;
      goal_j        = 8'd0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               i_in     = '0;
               c_in     = CARD_W'(1);
               ok_in    = 1'b1;
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            mult_in[i_ff] = c_ff;
            if (ok_ff && (goal_cur != 8'd0)) begin
               if (shape_n > 22'(PLY_LIMIT)) begin
                  ok_in = 1'b0;
               end else begin
                  c_in = shape_n[CARD_W-1:0];
               end
            end
            i_in = i_ff + ITEM_W'(1);
            if (i_ff == ITEM_W'(MAX_ITEMS - 1)) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            clr_in   = '0;
            state_in = ST_QUERY;
            case (req_ff.func)
               FUNC_LOAD: begin
                  oc_we = 1'b1;
               end
               FUNC_RESTART: begin
                  dst_sel_in    = 1'b0;
                  ply_select_in = 1'b0;
                  ply_count_in  = '0;
                  dist_ptr_in   = '0;
                  started_in    = 1'b1;
                  state_in      = ST_CLEAR;
               end
               FUNC_STEP: begin
                  if (started_ff && ok_ff) begin
                     d_in        = d_sel;
                     dist_ptr_in = (d_next >= n_dist) ? '0 : d_next[DIST_W-1:0];
                     dst_sel_in  = ~ply_select_ff;
                     state_in    = ST_CLEAR;
                  end
               end
               default: begin
                  state_in = ST_QUERY;
               end
            endcase
         end
         ST_CLEAR: begin
            // restart seeds the zero-count state with probability one
            mem_we    = 1'b1;
            mem_waddr = {dst_sel_ff, clr_ff};
            if ((req_ff.func == FUNC_RESTART) && (clr_ff == '0)) begin
               mem_wdata = {1'b1, PROB_ONE};
            end
            clr_in = clr_ff + PLY_AW'(1);
            if (clr_ff == {PLY_AW{1'b1}}) begin
               if (req_ff.func == FUNC_RESTART) begin
                  state_in = ST_QUERY;
               end else begin
                  idx_in = '0;
                  for (int j = 0; j < MAX_ITEMS; j++) begin
                     cnt_in[j] = 8'd0;
                  end
                  state_in = ST_SRC;
               end
            end
         end
         ST_SRC: begin
            if (idx_ff == c_ff) begin
               ply_select_in = dst_sel_ff;
               ply_count_in  = ply_count_ff + 16'd1;
               state_in      = ST_QUERY;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = {ply_select_ff, idx_ff[PLY_AW-1:0]};
               state_in  = ST_SRC_WAIT;
            end
         end
         ST_SRC_WAIT: begin
            p_in = ply_rdata_ff[PROB_BITS-1:0];
            i_in = '0;
            if (ply_rdata_ff[PROB_BITS]) begin
               state_in = ST_OC;
            end else begin
               state_in = ST_SRC;
            end
         end
         ST_OC: begin
            oc_re    = 1'b1;
            pres_in  = present_ff[{d_ff, i_ff}];
            state_in = ST_OC_WAIT;
         end
         ST_OC_WAIT: begin
            if (pres_ff && ({1'b0, i_ff} < items_used)) begin
               prod_in   = (2*PROB_BITS)'(p_ff) *
                           (2*PROB_BITS)'(oc_rdata_ff[PROB_BITS-1:0]);
               nidx_in   = nidx_full[PLY_AW-1:0];
               mem_re    = 1'b1;
               mem_raddr = {dst_sel_ff, nidx_full[PLY_AW-1:0]};
               state_in  = ST_DST_WAIT;
            end else begin
               i_in = i_ff + ITEM_W'(1);
               state_in = (i_ff == ITEM_W'(MAX_ITEMS - 1)) ? ST_SRC : ST_OC;
            end
         end
         ST_DST_WAIT: begin
            mem_we    = 1'b1;
            mem_waddr = {dst_sel_ff, nidx_ff};
            mem_wdata = {1'b1, put_val};
            i_in      = i_ff + ITEM_W'(1);
            state_in  = (i_ff == ITEM_W'(MAX_ITEMS - 1)) ? ST_SRC : ST_OC;
         end
         ST_QUERY: begin
            if (!started_ff) begin
               status_in = STATUS_NOT_STARTED;
            end else if (!ok_ff) begin
               status_in = STATUS_TOO_LARGE;
            end else begin
               status_in = STATUS_OK;
               mem_re    = 1'b1;
               mem_raddr = {ply_select_ff, query_addr};
            end
            state_in = ST_QUERY_WAIT;
         end
         ST_QUERY_WAIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.reach_prob = ((status_ff == STATUS_OK) && ply_rdata_ff[PROB_BITS]) ?
                                   ply_rdata_ff[PROB_BITS-1:0] : '0;
               rsp_in.status       = status_ff;
               rsp_in.plies_done   = ply_count_ff;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // mixed-radix increment of the source state index
      if ((state_ff == ST_SRC_WAIT && !ply_rdata_ff[PROB_BITS]) ||
          ((state_ff == ST_OC_WAIT || state_ff == ST_DST_WAIT) &&
           state_in == ST_SRC)) begin
         idx_in = idx_ff + CARD_W'(1);
         carry  = 1'b1;
         for (int j = 0; j < MAX_ITEMS; j++) begin
            goal_j = goal_of(ITEM_W'(j), items_used, goal_counts_ff);
            if (carry && (goal_j != 8'd0)) begin
               if (cnt_ff[j] == goal_j) begin
                  cnt_in[j] = 8'd0;
               end else begin
                  cnt_in[j] = cnt_ff[j] + 8'd1;
                  carry     = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ply_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         ply_rdata_ff <= ply_mem[mem_raddr];
      end
      if (oc_we) begin
         oc_mem[{req_ff.dist_index, req_ff.item_index}] <= {req_ff.reward, load_prob};
      end
      if (oc_re) begin
         oc_rdata_ff <= oc_mem[oc_raddr];
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      i_ff     <= i_in;
      c_ff     <= c_in;
      ok_ff    <= ok_in;
      mult_ff  <= mult_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      clr_ff   <= clr_in;
      dst_sel_ff <= dst_sel_in;
      d_ff     <= d_in;
      p_ff     <= p_in;
      pres_ff  <= pres_in;
      prod_ff  <= prod_in;
      nidx_ff  <= nidx_in;
      status_ff <= status_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         dist_ptr_ff    <= '0;
         ply_select_ff  <= 1'b0;
         ply_count_ff   <= '0;
         started_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         present_ff     <= '0;
         item_count_ff  <= 4'd1;
         dist_count_ff  <= 5'd1;
         goal_counts_ff <= '0;
      end else begin
         state_ff      <= state_in;
         dist_ptr_ff   <= dist_ptr_in;
         ply_select_ff <= ply_select_in;
         ply_count_ff  <= ply_count_in;
         started_ff    <= started_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (oc_we) begin
            present_ff[{req_ff.dist_index, req_ff.item_index}] <= req_ff.outcome_present;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_ITEM_COUNT:  item_count_ff  <= csr_wdata[3:0];
               CSR_DIST_COUNT:  dist_count_ff  <= csr_wdata[4:0];
               CSR_GOAL_COUNTS: goal_counts_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   `GRPPE_ASSERT_IMPL(ok_needs_start, clock, reset,
      rsp_valid_ff && (rsp_ff.status == STATUS_OK), started_ff,
      "ok status before restart")
   `GRPPE_ASSERT_IMPL(merge_hits_dst, clock, reset,
      state_ff == ST_DST_WAIT, mem_we && (mem_waddr[PLY_AW] == dst_sel_ff),
      "merge write outside destination ply")
   `GRPPE_ASSERT_IMPL(src_in_range, clock, reset,
      state_ff == ST_SRC_WAIT, idx_ff < c_ff,
      "source index beyond state space")
   `GRPPE_ASSERT_NEXT(step_swaps_ply, clock, reset,
      (state_ff == ST_SRC) && (idx_ff == c_ff),
      (state_ff == ST_QUERY) && (ply_select_ff == $past(dst_sel_ff)),
      "ply select not swapped at end of step")

endmodule

### test/tb_goal_reach_probability_ply_engine_top.sv
// self-checking testbench for the goal reach probability ply engine top level
module tb_goal_reach_probability_ply_engine_top;
   import grppe_pkg::*;

   localparam logic [1:0] FUNC_NOP = 2'd3;
   localparam int CYCLE_LIMIT = 60_000_000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ITEM_COUNT;
   logic [63:0] csr_wdata = '0;

   goal_reach_probability_ply_engine_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   req_type pending_items[$];
   rsp_type expected_rsp[$];
   int      errors = 0;
   int      cycles = 0;
   bit      quiet = 1'b0;
   int      send_gap = 0;
   int      recv_stall = 0;

   // predictor copy of registers and engine state
   logic [3:0]  m_items = 4'd1;
   logic [4:0]  m_dists = 5'd1;
   logic [63:0] m_goals = '0;
   bit          oc_pres [16][8];
   logic [7:0]  oc_rew  [16][8];
   logic [31:0] oc_prob [16][8];
   logic [31:0] ply_p [2][PLY_SIZE];
   bit          ply_v [2][PLY_SIZE];
   logic [15:0] plies = '0;
   int unsigned dist_ptr = 0;
   int unsigned ply_sel = 0;
   bit          started = 1'b0;
   int unsigned sp_mult [8];
   int unsigned sp_card = 1;

   function automatic int unsigned items_used();
      return (m_items > MAX_ITEMS) ? MAX_ITEMS : m_items;
   endfunction

   function automatic int unsigned goal_of(int unsigned i);
      if (i >= items_used()) return 0;
      return m_goals[8*i +: 8];
   endfunction

   // radix multipliers and state count; returns 0 if the space exceeds the ply memory
   function automatic bit fit_space();
      longint unsigned c, n;
      int unsigned g;
      c = 1;
      for (int i = 0; i < MAX_ITEMS; i++) begin
         g = goal_of(i);
         sp_mult[i] = 32'(c);
         if (g != 0) begin
            n = c * (g + 1);
            if (n > PLY_SIZE) return 1'b0;
            c = n;
         end
      end
      sp_card = 32'(c);
      return 1'b1;
   endfunction

   function automatic logic [31:0] mul_trunc(logic [31:0] a, logic [31:0] b);
      logic [63:0] r;
      r = ({32'd0, a} * {32'd0, b}) >> FRAC;
      return (r > PROB_ONE) ? PROB_ONE : r[31:0];
   endfunction

   function automatic void merge_into(int unsigned sel, int unsigned idx, logic [31:0] p);
      logic [32:0] s;
      if (ply_v[sel][idx]) begin
         s = {1'b0, ply_p[sel][idx]} + {1'b0, p};
         ply_p[sel][idx] = (s > PROB_ONE) ? PROB_ONE : s[31:0];
      end else begin
         ply_p[sel][idx] = p;
      end
      ply_v[sel][idx] = 1'b1;
   endfunction

   function automatic void apply_dist();
      int unsigned n, d, src, dst, cnt, nc, nidx, g, nit;
      int unsigned gl [8];
      logic [31:0] p;
      if (!started || !fit_space()) return;
      nit = items_used();
      n = (m_dists == 0) ? 1 : ((m_dists > MAX_DISTS) ? MAX_DISTS : m_dists);
      d = (dist_ptr >= n) ? 0 : dist_ptr;
      dist_ptr = (d + 1 >= n) ? 0 : d + 1;
      src = ply_sel;
      dst = src ^ 1;
      for (int k = 0; k < PLY_SIZE; k++) ply_v[dst][k] = 1'b0;
      for (int i = 0; i < MAX_ITEMS; i++) gl[i] = goal_of(i);
      for (int unsigned idx = 0; idx < sp_card; idx++) begin
         if (ply_v[src][idx]) begin
            p = ply_p[src][idx];
            for (int unsigned i = 0; i < nit; i++) begin
               if (oc_pres[d][i]) begin
                  nidx = idx;
                  g = gl[i];
                  if (g != 0) begin
                     cnt = (idx / sp_mult[i]) % (g + 1);
                     if (cnt < g) begin
                        nc = cnt + oc_rew[d][i];
                        if (nc > g) nc = g;
                        nidx = idx + (nc - cnt) * sp_mult[i];
                     end
                  end
                  merge_into(dst, nidx, mul_trunc(p, oc_prob[d][i]));
               end
            end
         end
      end
      plies = plies + 16'd1;
      ply_sel = dst;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      o = '0;
      case (r.func)
         FUNC_LOAD: begin
            oc_pres[r.dist_index][r.item_index] = r.outcome_present;
            oc_rew[r.dist_index][r.item_index]  = r.reward;
            oc_prob[r.dist_index][r.item_index] =
               (r.probability > PROB_ONE) ? PROB_ONE : r.probability;
         end
         FUNC_RESTART: begin
            for (int k = 0; k < PLY_SIZE; k++) begin
               ply_v[0][k] = 1'b0;
               ply_v[1][k] = 1'b0;
            end
            ply_sel = 0;
            ply_p[0][0] = PROB_ONE;
            ply_v[0][0] = 1'b1;
            plies = '0;
            dist_ptr = 0;
            started = 1'b1;
         end
         FUNC_STEP: apply_dist();
         default: ;
      endcase
      if (!started) o.status = STATUS_NOT_STARTED;
      else if (!fit_space()) o.status = STATUS_TOO_LARGE;
      else o.status = STATUS_OK;
      if (o.status == STATUS_OK && ply_v[ply_sel][sp_card-1])
         o.reach_prob = ply_p[ply_sel][sp_card-1];
      o.plies_done = plies;
      return o;
   endfunction

   task automatic report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h expected %0h", field, got, want);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      logic    nv;
      req_type np;
      cycles++;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         nv = req_valid;
         np = req_payload;
         if (req_valid && req_ready) begin
            expected_rsp.push_back(predict_rsp(req_payload));
            nv = 1'b0;
         end
         if (!nv) begin
            if (send_gap > 0) send_gap--;
            else if (pending_items.size() > 0) begin
               if (!quiet && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 6);
               else begin
                  np = pending_items.pop_front();
                  nv = 1'b1;
               end
            end
         end
         req_valid <= nv;
         req_payload <= np;
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               report("unexpected transaction", rsp_payload.reach_prob, '0);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_payload.reach_prob !== want.reach_prob)
                  report("reach_prob", rsp_payload.reach_prob, want.reach_prob);
               if (rsp_payload.status !== want.status)
                  report("status", rsp_payload.status, want.status);
               if (rsp_payload.plies_done !== want.plies_done)
                  report("plies_done", rsp_payload.plies_done, want.plies_done);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            recv_stall = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type mk(logic [1:0] f, logic [3:0] di, logic [2:0] ii,
                                  logic pres, logic [7:0] rew, logic [31:0] prob);
      req_type r;
      r.func = f;
      r.dist_index = di;
      r.item_index = ii;
      r.outcome_present = pres;
      r.reward = rew;
      r.probability = prob;
      return r;
   endfunction

   function automatic req_type rand_load(int unsigned d, int unsigned i);
      logic [7:0]  rew;
      logic [31:0] prob;
      rew = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
         0, 1: prob = $urandom;
         2: prob = PROB_ONE;
         default: prob = $urandom_range(0, 32'h8000_0000);
      endcase
      return mk(FUNC_LOAD, 4'(d), 3'(i), $urandom_range(0, 4) != 0, rew, prob);
   endfunction

   function automatic req_type rand_noise();
      return mk(2'($urandom), 4'($urandom), 3'($urandom), 1'($urandom),
                8'($urandom), $urandom);
   endfunction

   task automatic csr_write(logic [1:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_ITEM_COUNT:  m_items = val[3:0];
         CSR_DIST_COUNT:  m_dists = val[4:0];
         default:         m_goals = val;
      endcase
   endtask

   task automatic drain();
      while (pending_items.size() != 0 || expected_rsp.size() != 0 || req_valid)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      logic [63:0] goals;
      int unsigned nd, ni;
      for (int d = 0; d < 16; d++)
         for (int i = 0; i < 8; i++) begin
            oc_pres[d][i] = 1'b0;
            oc_rew[d][i] = '0;
            oc_prob[d][i] = '0;
         end
      for (int k = 0; k < PLY_SIZE; k++) begin
         ply_v[0][k] = 1'b0;
         ply_v[1][k] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // step before restart, no-op, load extremes, then a first ply
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_NOP, 4'hF, 3'h7, 1, 8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk(FUNC_LOAD, 0, 0, 1, 8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk(FUNC_LOAD, 4'hF, 3'h7, 1, 8'h00, PROB_ONE));
      pending_items.push_back(mk(FUNC_RESTART, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_LOAD, 0, 0, 1, 8'h01, 32'h0000_0000));
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      drain();

      // state space too large, steps do nothing
      csr_write(CSR_ITEM_COUNT, 64'd8);
      csr_write(CSR_DIST_COUNT, 64'd16);
      csr_write(CSR_GOAL_COUNTS, 64'hFFFF_FFFF_FFFF_FFFF);
      pending_items.push_back(mk(FUNC_RESTART, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_LOAD, 4'h3, 3'h1, 1, 8'h02, 32'h4000_0000));
      drain();

      // full ply memory, item count above max, dist count zero and then above max
      csr_write(CSR_ITEM_COUNT, {60'hABCDE, 4'hF});
      csr_write(CSR_DIST_COUNT, 64'd0);
      csr_write(CSR_GOAL_COUNTS, 64'h0000_0000_0000_3F3F);
      pending_items.push_back(mk(FUNC_LOAD, 0, 1, 1, 8'h05, 32'h4000_0000));
      pending_items.push_back(mk(FUNC_LOAD, 0, 2, 1, 8'h01, 32'h2000_0000));
      pending_items.push_back(mk(FUNC_RESTART, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      drain();
      csr_write(CSR_DIST_COUNT, {59'h1234, 5'd31});
      pending_items.push_back(mk(FUNC_STEP, 0, 0, 0, 0, 0));
      drain();

      // random well-formed runs with noise mixed in
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 6) quiet = 1'b1;
         goals = '0;
         for (int i = 0; i < 8; i++)
            if ($urandom_range(0, 1)) goals[8*i +: 8] = 8'($urandom_range(1, 3));
         if ($urandom_range(0, 5) == 0) goals[8*$urandom_range(0, 7) +: 8] = 8'hFF;
         csr_write(CSR_GOAL_COUNTS, goals);
         csr_write(CSR_ITEM_COUNT,
                   ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 15))
                                               : 64'($urandom_range(1, 8)));
         csr_write(CSR_DIST_COUNT,
                   ($urandom_range(0, 5) == 0) ? 64'($urandom_range(0, 31))
                                               : 64'($urandom_range(1, 3)));
         nd = (m_dists == 0) ? 1 : ((m_dists > 3) ? 3 : m_dists);
         ni = (items_used() > 4) ? 4 : items_used();
         for (int d = 0; d < nd; d++)
            for (int i = 0; i < ni; i++)
               if ($urandom_range(0, 2) != 0) pending_items.push_back(rand_load(d, i));
         pending_items.push_back(mk(FUNC_RESTART, 0, 0, 0, 0, 0));
         for (int s = 0; s < 5; s++) begin
            pending_items.push_back(mk(FUNC_STEP, 4'($urandom), 3'($urandom), 0, 0, 0));
            if ($urandom_range(0, 3) == 0) pending_items.push_back(rand_noise());
            if ($urandom_range(0, 4) == 0)
               pending_items.push_back(rand_load($urandom_range(0, 15), $urandom_range(0, 7)));
         end
         drain();
      end

      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
